// ===== rtl/lkvc_pkg.sv =====
// lkvc_pkg: shared constants, types and state codes for the lru key-value cache
// used by every module of the block; depends on nothing

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    localparam int IN_TDATA_W = KEY_W + VAL_W;
    localparam int OUT_FIELD_W = 1 + VAL_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic lookup;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } state_t;

endpackage

// ===== rtl/lkvc_cell.sv =====
// lkvc_cell: one cache slot of the recency chain, holding a key, a value and a match flag
// depends on lkvc_pkg; cell 0 holds the most recent entry

module lkvc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lkvc_pkg::cell_ctrl_t      ctrl,
    input  logic [lkvc_pkg::KEY_W-1:0] cmp_key,
    input  lkvc_pkg::entry_t          prev_entry,
    output lkvc_pkg::entry_t          entry,
    output logic                      match
);
    import lkvc_pkg::*;

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic             match_reg, match_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.shift)
        begin
            valid_next = prev_entry.valid;
            key_next   = prev_entry.key;
            value_next = prev_entry.value;
        end
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.lookup)
        begin
            match_next = valid_reg && (key_reg == cmp_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;
    assign match       = match_reg;

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// lru_key_value_cache_unit: top level of the fully associative lru key-value cache
// depends on lkvc_pkg and lkvc_cell

// The cache is a chain of ENTRIES cells kept in recency order, cell 0 most recent.
// In the cycle a request word is accepted every cell compares its key against the
// request, and in the update state that follows the chain shifts by one cell up
// to the hit (or across the whole chain for an insert) while the result is loaded
// into the output register. A stalled result holds the block in its update cycle
// until the output register frees up. cfg_wdata sets the capacity in use (0 acts as
// 1, values above ENTRIES act as ENTRIES); write it only while the block is idle.

module lru_key_value_cache_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]      s_tdata,   // lookup_key, write_value
    input  logic                                 s_tuser,   // kind
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lkvc_pkg::OUT_TDATA_W-1:0]     m_tdata    // hit, read_value, evicted
);
    import lkvc_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] wval_reg;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic accept;
    logic apply_fire;

    cell_ctrl_t             ctrl   [ENTRIES];
    entry_t                 ent    [ENTRIES];
    entry_t                 prev   [ENTRIES];
    logic [ENTRIES-1:0]     match_vec;
    logic [ENTRIES-1:0]     valid_vec;
    logic [ENTRIES-1:0]     hit_ge;
    entry_t                 head;

    logic             hit;
    logic [VAL_W-1:0] hit_value;
    logic             full;
    logic             put_miss;
    logic             evicted;

    // capacity clamp
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if (int'(cap_reg) > ENTRIES)
            cap_eff = CNT_W'(ENTRIES);
        else
            cap_eff = CNT_W'(cap_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        apply_fire = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_APPLY:
            begin
                apply_fire = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_W-1:0];
            wval_reg <= s_tdata[KEY_W +: VAL_W];
        end
    end

    // hit detection and value select
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
                hit_value = hit_value | ent[i].value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_ge[i] = |(match_vec & ({ENTRIES{1'b1}} << i));
        end
    end

    assign hit      = |match_vec;
    assign full     = count_reg >= cap_eff;
    assign put_miss = (kind_reg == OP_PUT) && !hit;
    assign evicted  = put_miss && full;

    assign head.valid = 1'b1;
    assign head.key   = key_reg;
    assign head.value = (kind_reg == OP_GET) ? hit_value : wval_reg;

    // per-cell control
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ctrl[i].lookup = accept;
            ctrl[i].shift  = apply_fire && (hit ? hit_ge[i] : put_miss);
            ctrl[i].clear  = apply_fire && evicted && (CNT_W'(i) >= cap_eff);
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign prev[g] = head;
            end
            else
            begin : g_link
                assign prev[g] = ent[g-1];
            end

            lkvc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .cmp_key    (s_tdata[KEY_W-1:0]),
                .prev_entry (prev[g]),
                .entry      (ent[g]),
                .match      (match_vec[g])
            );

            assign valid_vec[g] = ent[g].valid;
        end
    endgenerate

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (apply_fire && put_miss)
        begin
            if (full)
                count_next = cap_eff;
            else
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        if (apply_fire)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {(OUT_TDATA_W - OUT_FIELD_W)'(0),
                             evicted,
                             (hit && (kind_reg == OP_GET)) ? hit_value : VAL_W'(0),
                             hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // keys in the chain are unique
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    // valid cells and the entry count agree
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == 32'($countones(valid_vec)))
        else $error("entry count differs from valid cells");

    // valid cells form a run from the head of the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + ENTRIES'(1))) == '0))
        else $error("gap in the recency chain");

    // an eviction never comes with a hit or a read value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[OUT_FIELD_W-1]) |-> (!m_tdata[0] && (m_tdata[VAL_W:1] == '0)))
        else $error("eviction reported together with a hit");

    // an accepted word moves the block into its update state in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_APPLY))
        else $error("accepted word not applied");
`endif

endmodule

// ===== test/lru_cache_checker.sv =====
`timescale 1ns / 100ps
// lru_cache_checker: watches the request, reply and config channels of the lru key-value cache,
// predicts each reply and compares it field by field; depends on lkvc_pkg

module lru_cache_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lkvc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lkvc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                               fail_count,
    output int                               outstanding
);
    import lkvc_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } reply_t;

    logic             line_valid [ENTRIES];
    logic [KEY_W-1:0] line_key   [ENTRIES];
    logic [VAL_W-1:0] line_value [ENTRIES];
    logic [4:0]       line_rank  [ENTRIES];
    logic [CNT_W-1:0] line_count;
    logic [CFG_W-1:0] capacity;

    reply_t reply_q [$];
    reply_t want;
    reply_t got;
    int     word_errs;

    function automatic void age_lines(int s, int limit);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (line_valid[i] && line_rank[i] < limit)
                line_rank[i] = line_rank[i] + 5'(1);
        end
        line_rank[s] = '0;
    endfunction

    function automatic reply_t cache_access(logic kind, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
        reply_t     r;
        int         found;
        int         slot;
        logic [4:0] cap;
        r = '0;
        found = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (found < 0 && line_valid[i] && line_key[i] == key)
                found = i;
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (kind == OP_GET)
                r.read_value = line_value[found];
            else
                line_value[found] = val;
            age_lines(found, line_rank[found]);
        end
        else if (kind == OP_PUT)
        begin
            // zero acts as one, above ENTRIES saturates
            cap = capacity;
            if (cap == 0)
                cap = 5'(1);
            if (cap > ENTRIES)
                cap = 5'(ENTRIES);
            // a lowered capacity drops every line past the new limit at once
            if (line_count >= cap)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (line_valid[i] && line_rank[i] >= cap - 5'(1))
                    begin
                        line_valid[i] = 1'b0;
                        r.evicted = 1'b1;
                    end
                end
                line_count = CNT_W'(cap - 5'(1));
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && !line_valid[i])
                    slot = i;
            end
            if (slot >= 0)
            begin
                age_lines(slot, ENTRIES);
                line_valid[slot] = 1'b1;
                line_key[slot] = key;
                line_value[slot] = val;
                line_rank[slot] = '0;
                line_count = line_count + CNT_W'(1);
            end
        end
        return r;
    endfunction

    task automatic report(string field, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
        $display("%0t: reply %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
        word_errs++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_valid[i] = 1'b0;
                line_key[i] = '0;
                line_value[i] = '0;
                line_rank[i] = '0;
            end
            line_count = '0;
            capacity = CAP_RESET;
            reply_q.delete();
            outstanding <= 0;
            fail_count <= 0;
        end
        else
        begin
            word_errs = 0;
            if (m_tvalid && m_tready)
            begin
                got.hit = m_tdata[0];
                got.read_value = m_tdata[VAL_W:1];
                got.evicted = m_tdata[VAL_W+1];
                if (reply_q.size() == 0)
                begin
                    $display("%0t: unexpected reply word, expected none, actual %h",
                             $time, m_tdata);
                    word_errs++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.hit !== want.hit)
                        report("hit", VAL_W'(want.hit), VAL_W'(got.hit));
                    if (got.read_value !== want.read_value)
                        report("read_value", want.read_value, got.read_value);
                    if (got.evicted !== want.evicted)
                        report("evicted", VAL_W'(want.evicted), VAL_W'(got.evicted));
                end
            end
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_tvalid && s_tready)
                reply_q.push_back(cache_access(s_tuser, s_tdata[KEY_W-1:0],
                                               s_tdata[KEY_W+VAL_W-1:KEY_W]));
            outstanding <= reply_q.size();
            fail_count <= fail_count + word_errs;
        end
    end

endmodule

// ===== test/tb_lru_key_value_cache_unit.sv =====
`timescale 1ns / 100ps
// tb_lru_key_value_cache_unit: drives directed and random get/put words and capacity
// settings into the lru key-value cache; depends on lkvc_pkg, lru_key_value_cache_unit and lru_cache_checker

module tb_lru_key_value_cache_unit;
    import lkvc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int errors;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet = 0;

    logic [KEY_W-1:0] key_pool [24];
    int               pool_n;
    logic [CFG_W-1:0] caps [10] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd8, 5'd17, 5'd5, 5'd2,
                                    5'd12};
    logic [KEY_W-1:0] corner [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};

    lru_key_value_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lru_cache_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb_lru_key_value_cache_unit: FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {val, key};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CFG_W-1:0] cap);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return $urandom;
        if (r < 11)
            return corner[2'($urandom_range(3))];
        return key_pool[5'($urandom_range(pool_n - 1))];
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(9) == 0)
            return corner[2'($urandom_range(3))];
        return $urandom;
    endfunction

    initial
    begin
        int eff;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty miss, signed extremes, update, then capacity lowered under the count
        send_word(OP_GET, 32'h0000_0000, 32'hdead_beef);
        send_word(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
        send_word(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
        send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_GET, 32'h7fff_ffff, 32'hffff_ffff);
        send_word(OP_PUT, 32'h8000_0000, 32'hffff_ffff);
        send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_PUT, 32'hffff_ffff, 32'h5a5a_5a5a);
        send_word(OP_GET, 32'hffff_ffff, 32'h0000_0000);
        set_capacity(CFG_W'(2));
        send_word(OP_GET, 32'h7fff_ffff, 32'h0000_0000);
        send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_PUT, 32'h0000_0001, 32'ha5a5_a5a5);
        send_word(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_PUT, 32'h0000_0000, 32'h0000_0001);
        // zero acts as one
        set_capacity(CFG_W'(0));
        send_word(OP_PUT, 32'h0000_0002, 32'h0000_0002);
        send_word(OP_GET, 32'h0000_0001, 32'h0000_0000);
        send_word(OP_PUT, 32'h0000_0003, 32'h0000_0003);
        send_word(OP_GET, 32'h0000_0003, 32'h0000_0000);
        send_word(OP_GET, 32'h0000_0002, 32'h0000_0000);
        // saturates at ENTRIES
        set_capacity(CFG_W'(31));
        send_word(OP_PUT, 32'h0000_0004, 32'h0000_0004);
        send_word(OP_GET, 32'h0000_0003, 32'h0000_0000);

        for (int p = 0; p < 10; p++)
        begin
            set_capacity(caps[p]);
            eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
            pool_n = eff + $urandom_range(1, 6);
            for (int i = 0; i < 24; i++)
                key_pool[i] = $urandom;
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ((p == 5 && n == PHASE_WORDS / 2) || $urandom_range(199) == 0)
                    drain();
                send_word(logic'($urandom_range(1)), pick_key(), pick_value());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_lru_key_value_cache_unit: PASS");
        else
            $display("tb_lru_key_value_cache_unit: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache_unit.sv
test/lru_cache_checker.sv
test/tb_lru_key_value_cache_unit.sv
